/* rtl/pse_pkg.sv */
// Shared types and constants for the polyline stroke extruder.
package pse_pkg;

    localparam int CoordW = 24;
    localparam int DiffW  = 25;
    localparam int WorldW = 96;
    localparam int LenW   = 32;
    localparam int WidthW = 16;
    localparam int SqW    = 50;
    localparam int RootW  = 32;
    localparam int RemW   = 34;
    localparam int DvdW   = 49;
    localparam int QuoW   = 18;
    localparam int OffW   = 19;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_ROOT,
        ST_NUMX,
        ST_DIVX,
        ST_NUMY,
        ST_DIVY,
        ST_EMIT_M,
        ST_EMIT_P,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        JOB_A,
        JOB_SEG,
        JOB_LAST
    } job_t;

    function automatic logic signed [CoordW-1:0] sat24(input logic signed [CoordW+1:0] v);
        logic signed [CoordW+1:0] hi;
        logic signed [CoordW+1:0] lo;
        hi = 26'sd8388607;
        lo = -26'sd8388608;
        if (v > hi)
        begin
            return 24'sh7FFFFF;
        end
        else if (v < lo)
        begin
            return 24'sh800000;
        end
        return v[CoordW-1:0];
    endfunction

endpackage

/* rtl/pse_sqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
module pse_sqrt
    import pse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        value,
    output logic               done,
    output logic [RootW-1:0]   root,
    output logic [RemW-1:0]    rem
);

    logic [63:0]      val_reg;
    logic [RemW-1:0]  rem_reg;
    logic [RootW-1:0] root_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RemW+1:0]  trial_rem;
    logic [RemW+1:0]  trial;
    logic             take;

    assign trial_rem = {rem_reg, val_reg[63:62]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign take      = (trial_rem >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[61:0], 2'b00};
            if (take)
            begin
                rem_reg  <= RemW'(trial_rem - trial);
                root_reg <= {root_reg[RootW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial_rem[RemW-1:0];
                root_reg <= {root_reg[RootW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/pse_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module pse_div
    import pse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DvdW-1:0]  dividend,
    input  logic [RemW-1:0]  divisor,
    output logic             done,
    output logic [QuoW-1:0]  quotient
);

    logic [DvdW-1:0] dvd_reg;
    logic [RemW-1:0] dsr_reg;
    logic [RemW-1:0] rem_reg;
    logic [QuoW-1:0] quo_reg;
    logic [5:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [RemW:0]   trial_rem;
    logic            take;

    assign trial_rem = {rem_reg, dvd_reg[DvdW-1]};
    assign take      = (trial_rem >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DvdW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DvdW-2:0], 1'b0};
            if (take)
            begin
                rem_reg <= RemW'(trial_rem - {1'b0, dsr_reg});
            end
            else
            begin
                rem_reg <= trial_rem[RemW-1:0];
            end
            quo_reg <= {quo_reg[QuoW-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/polyline_stroke_extruder.sv */
// Top level of the polyline stroke extruder: sequencer, point state and ports.
//
// Each point yields two vertices (minus side, then plus side) one point late; a point
// marked tlast flushes both pending points. One point at a time is in work. A normal
// costs four multiplies, a bit-serial square root and two bit-serial divisions (the
// root and divisions are skipped for a zero chord); the segment length adds a second
// bit-serial root. The output side can stall the vertex emit states.
module polyline_stroke_extruder
    import pse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // win_x[23:0], win_y[47:24], world_x[79:48], world_y[111:80], world_z[143:112]
    input  logic [143:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vert_x[23:0], vert_y[47:24], vert_world_x[79:48], vert_world_y[111:80],
    // vert_world_z[143:112], tex_u[175:144], tex_v[191:176]
    output logic [191:0] m_axis_tdata,
    // side[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    state_t state_reg, state_next;
    job_t   job_reg;

    logic [WidthW-1:0]        width_reg;
    logic signed [CoordW-1:0] prior_x_reg, prior_y_reg, held_x_reg, held_y_reg;
    logic [WorldW-1:0]        held_world_reg;
    logic [LenW-1:0]          held_len_reg;
    logic [1:0]               seen_reg;

    logic signed [CoordW-1:0] cur_x_reg, cur_y_reg, pt_x_reg, pt_y_reg;
    logic [WorldW-1:0]        cur_world_reg, pt_world_reg;
    logic                     cur_fin_reg, pt_last_reg;
    logic [LenW-1:0]          pt_len_reg, new_len_reg;
    logic signed [DiffW-1:0]  dx_reg, dy_reg;
    logic [SqW-1:0]           prod_reg, s_reg;
    logic [RootW-1:0]         l_reg;
    logic [QuoW-1:0]          mx_reg;
    logic signed [OffW-1:0]   ox_reg, oy_reg;

    logic                     in_beat, out_beat, cfg_wr;
    logic signed [CoordW-1:0] in_x, in_y;
    logic [DiffW-1:0]         ax, ay;
    logic                     dx_pos, dy_pos;
    logic                     sq_start, sq_done, dv_start, dv_done;
    logic [63:0]              sq_value;
    logic [RootW-1:0]         sq_root;
    logic [RemW-1:0]          sq_rem;
    logic [DvdW-1:0]          dv_dividend;
    logic [QuoW-1:0]          dv_quo;
    logic [DiffW-1:0]         num_mag;
    logic [DiffW+WidthW-1:0]  num_prod;
    logic [RootW:0]           seg;
    logic [LenW+1:0]          len_sum;
    logic [LenW-1:0]          len_sat;
    logic signed [OffW-1:0]   ox_s, oy_s;
    logic signed [CoordW+1:0] vx_sum, vy_sum;
    logic [WidthW-1:0]        half;
    logic [WidthW-1:0]        tex_v;

    assign in_x     = s_axis_tdata[23:0];
    assign in_y     = s_axis_tdata[47:24];
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {16'd0, width_reg} : 32'd0;

    assign ax     = dx_reg[DiffW-1] ? DiffW'(-dx_reg) : DiffW'(dx_reg);
    assign ay     = dy_reg[DiffW-1] ? DiffW'(-dy_reg) : DiffW'(dy_reg);
    assign dx_pos = !dx_reg[DiffW-1] && (dx_reg != '0);
    assign dy_pos = !dy_reg[DiffW-1] && (dy_reg != '0);

    assign sq_value = (job_reg == JOB_SEG) ? {14'd0, s_reg} : {s_reg, 14'd0};
    assign num_mag  = (state_reg == ST_NUMX) ? ay : ax;
    assign num_prod = (DiffW+WidthW)'(num_mag) * (DiffW+WidthW)'(width_reg);
    assign dv_dividend = DvdW'({num_prod, 7'd0}) + DvdW'(l_reg);
    assign seg      = {1'b0, sq_root} + ((sq_rem > RemW'(sq_root)) ? 33'd1 : 33'd0);
    assign len_sum  = {2'b00, held_len_reg} + (LenW+2)'(seg);
    assign len_sat  = (len_sum[LenW+1:LenW] != 2'b00) ? {LenW{1'b1}} : len_sum[LenW-1:0];

    pse_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .done  (sq_done),
        .root  (sq_root),
        .rem   (sq_rem)
    );

    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_dividend),
        .divisor  ({1'b0, l_reg, 1'b0}),
        .done     (dv_done),
        .quotient (dv_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && !(seen_reg == 2'd0 && !s_axis_tlast))
                begin
                    state_next = ST_SQ1;
                end
            end
            ST_SQ1:  state_next = ST_SQ2;
            ST_SQ2:  state_next = ST_SQ3;
            ST_SQ3:  state_next = (s_reg == '0 && job_reg != JOB_SEG) ? ST_EMIT_M : ST_ROOT;
            ST_ROOT:
            begin
                if (sq_done)
                begin
                    if (job_reg != JOB_SEG)
                    begin
                        state_next = ST_NUMX;
                    end
                    else if (cur_fin_reg)
                    begin
                        state_next = ST_SQ1;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_NUMX: state_next = ST_DIVX;
            ST_DIVX: state_next = dv_done ? ST_NUMY : ST_DIVX;
            ST_NUMY: state_next = ST_DIVY;
            ST_DIVY: state_next = dv_done ? ST_EMIT_M : ST_DIVY;
            ST_EMIT_M: state_next = out_beat ? ST_EMIT_P : ST_EMIT_M;
            ST_EMIT_P:
            begin
                if (out_beat)
                begin
                    state_next = (job_reg == JOB_A) ? ST_SQ1 : ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = (state_reg == ST_EMIT_M) || (state_reg == ST_EMIT_P);
        m_axis_tuser  = (state_reg == ST_EMIT_P);
        m_axis_tlast  = (state_reg == ST_EMIT_P) && pt_last_reg;
        sq_start      = (state_reg == ST_SQ3) && ((s_reg != '0) || (job_reg == JOB_SEG));
        dv_start      = (state_reg == ST_NUMX) || (state_reg == ST_NUMY);
    end

    assign ox_s   = m_axis_tuser ? ox_reg : -ox_reg;
    assign oy_s   = m_axis_tuser ? oy_reg : -oy_reg;
    assign vx_sum = (CoordW+2)'(pt_x_reg) + (CoordW+2)'(ox_s);
    assign vy_sum = (CoordW+2)'(pt_y_reg) + (CoordW+2)'(oy_s);
    assign half   = {1'b0, width_reg[WidthW-1:1]};
    assign tex_v  = m_axis_tuser ? half : WidthW'(-half);

    assign m_axis_tdata = {tex_v, pt_len_reg, pt_world_reg, sat24(vy_sum), sat24(vx_sum)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            job_reg        <= JOB_A;
            width_reg      <= 16'd256;
            prior_x_reg    <= '0;
            prior_y_reg    <= '0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_world_reg <= '0;
            held_len_reg   <= '0;
            seen_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && paddr[2] == 1'b0)
            begin
                width_reg <= pwdata[WidthW-1:0];
            end
            if (state_reg == ST_IDLE && in_beat)
            begin
                if (seen_reg == 2'd0)
                begin
                    job_reg <= JOB_LAST;
                    if (!s_axis_tlast)
                    begin
                        held_x_reg     <= in_x;
                        held_y_reg     <= in_y;
                        held_world_reg <= s_axis_tdata[143:48];
                        held_len_reg   <= '0;
                        seen_reg       <= 2'd1;
                    end
                end
                else
                begin
                    job_reg <= JOB_A;
                end
            end
            if (state_reg == ST_EMIT_P && out_beat && job_reg == JOB_A)
            begin
                job_reg <= JOB_SEG;
            end
            if (state_reg == ST_ROOT && sq_done && job_reg == JOB_SEG && cur_fin_reg)
            begin
                job_reg <= JOB_LAST;
            end
            if (state_reg == ST_FINISH)
            begin
                if (cur_fin_reg)
                begin
                    prior_x_reg    <= '0;
                    prior_y_reg    <= '0;
                    held_x_reg     <= '0;
                    held_y_reg     <= '0;
                    held_world_reg <= '0;
                    held_len_reg   <= '0;
                    seen_reg       <= '0;
                end
                else
                begin
                    prior_x_reg    <= held_x_reg;
                    prior_y_reg    <= held_y_reg;
                    held_x_reg     <= cur_x_reg;
                    held_y_reg     <= cur_y_reg;
                    held_world_reg <= cur_world_reg;
                    held_len_reg   <= new_len_reg;
                    seen_reg       <= 2'd2;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    cur_x_reg     <= in_x;
                    cur_y_reg     <= in_y;
                    cur_world_reg <= s_axis_tdata[143:48];
                    cur_fin_reg   <= s_axis_tlast;
                    if (seen_reg == 2'd0)
                    begin
                        pt_x_reg     <= in_x;
                        pt_y_reg     <= in_y;
                        pt_world_reg <= s_axis_tdata[143:48];
                        pt_len_reg   <= '0;
                        pt_last_reg  <= 1'b1;
                        dx_reg       <= '0;
                        dy_reg       <= '0;
                    end
                    else
                    begin
                        pt_x_reg     <= held_x_reg;
                        pt_y_reg     <= held_y_reg;
                        pt_world_reg <= held_world_reg;
                        pt_len_reg   <= held_len_reg;
                        pt_last_reg  <= 1'b0;
                        if (seen_reg == 2'd1)
                        begin
                            dx_reg <= DiffW'(in_x) - DiffW'(held_x_reg);
                            dy_reg <= DiffW'(in_y) - DiffW'(held_y_reg);
                        end
                        else
                        begin
                            dx_reg <= DiffW'(in_x) - DiffW'(prior_x_reg);
                            dy_reg <= DiffW'(in_y) - DiffW'(prior_y_reg);
                        end
                    end
                end
            end
            ST_SQ1: prod_reg <= SqW'(ax) * SqW'(ax);
            ST_SQ2: s_reg <= prod_reg + SqW'(ay) * SqW'(ay);
            ST_SQ3:
            begin
                if (s_reg == '0)
                begin
                    ox_reg <= '0;
                    oy_reg <= '0;
                end
            end
            ST_ROOT:
            begin
                if (sq_done)
                begin
                    if (job_reg != JOB_SEG)
                    begin
                        l_reg <= sq_root;
                    end
                    else
                    begin
                        new_len_reg <= len_sat;
                        if (cur_fin_reg)
                        begin
                            pt_x_reg     <= cur_x_reg;
                            pt_y_reg     <= cur_y_reg;
                            pt_world_reg <= cur_world_reg;
                            pt_len_reg   <= len_sat;
                            pt_last_reg  <= 1'b1;
                        end
                    end
                end
            end
            ST_DIVX:
            begin
                if (dv_done)
                begin
                    mx_reg <= dv_quo;
                end
            end
            ST_DIVY:
            begin
                if (dv_done)
                begin
                    ox_reg <= dy_pos ? -OffW'(mx_reg) : OffW'(mx_reg);
                    oy_reg <= dx_pos ? OffW'(dv_quo) : -OffW'(dv_quo);
                end
            end
            ST_EMIT_P:
            begin
                if (out_beat && job_reg == JOB_A)
                begin
                    dx_reg <= DiffW'(cur_x_reg) - DiffW'(held_x_reg);
                    dy_reg <= DiffW'(cur_y_reg) - DiffW'(held_y_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a vertex is pending");

    a_last_plus: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tlast |-> m_axis_tuser)
        else $error("run end on a minus-side vertex");

    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3)
        else $error("point count out of range");

    a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        sq_start |-> !dv_start)
        else $error("root and divider started together");

endmodule
